// File: src/c2dk_pkg.sv
// Shared constants, types and helpers for the 2D window convolution core.
`default_nettype none
package c2dk_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_KERNEL  = 7;
  localparam int DATA_WIDTH  = 16;
  localparam int LINE_SLOTS  = MAX_KERNEL - 1;
  localparam int COL_W       = 10;
  localparam int DIM_W       = 11;
  localparam int KSZ_W       = 3;
  localparam int SLOT_W      = 3;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int ROWSUM_W    = PROD_W + 3;
  localparam int VAL_W       = 37;
  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = 3;

  localparam logic [1:0] OP_COEF  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BIG  = 2'd1;
  localparam logic [1:0] ST_EVEN = 2'd2;

  localparam logic [1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [1:0] REG_KERNEL_ROWS = 2'd2;
  localparam logic [1:0] REG_KERNEL_COLS = 2'd3;

  typedef logic signed [DATA_WIDTH-1:0] pix_t;
  typedef logic [LINE_SLOTS-1:0][DATA_WIDTH-1:0] line_col_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [COL_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic [1:0]              status;
    logic                    frame_end;
  } res_t;

  typedef struct packed {
    logic             res;
    logic             use_sum;
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [1:0]       status;
    logic             frame_end;
  } meta_t;

  // line slot holding the row "back" rows above the one in slot
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
                                                  input logic [KSZ_W-1:0] back);
    logic [SLOT_W:0] t;
    t = {1'b0, slot} + (SLOT_W+1)'(LINE_SLOTS) - {1'b0, back};
    if (t >= (SLOT_W+1)'(LINE_SLOTS)) t = t - (SLOT_W+1)'(LINE_SLOTS);
    return t[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/c2dk_cell.sv
// One window cell: holds a pixel, passes it left, multiplies by its coefficient.
`default_nettype none
module c2dk_cell (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [c2dk_pkg::DATA_WIDTH-1:0] pix_in,
  input  wire logic signed [c2dk_pkg::DATA_WIDTH-1:0] coef,
  output logic signed [c2dk_pkg::DATA_WIDTH-1:0]      pix,
  output logic signed [c2dk_pkg::PROD_W-1:0]          prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      pix <= pix_in;
    end
    prod <= pix * coef;
  end

endmodule
`default_nettype wire

// File: src/c2dk_line_buf.sv
// Line store: one word per column holding all buffered rows, lane writes.
`default_nettype none
module c2dk_line_buf (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [c2dk_pkg::COL_W-1:0]           addr,
  input  wire logic [c2dk_pkg::SLOT_W-1:0]          slot,
  input  wire logic [c2dk_pkg::DATA_WIDTH-1:0]      wdata,
  output c2dk_pkg::line_col_t                       rdata
);

  c2dk_pkg::line_col_t mem [c2dk_pkg::MAX_COLS];

  // read returns the old column, before this word lands in it
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      mem[addr][slot] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: src/c2dk_out_fifo.sv
// Output queue of result words between the pipeline and the output channel.
`default_nettype none
module c2dk_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr,
  input  wire c2dk_pkg::res_t                wdata,
  input  wire logic                          rd,
  output c2dk_pkg::res_t                     rdata,
  output logic                               nonempty,
  output logic [c2dk_pkg::OFIFO_AW:0]        count
);

  c2dk_pkg::res_t mem [c2dk_pkg::OFIFO_DEPTH];
  logic [c2dk_pkg::OFIFO_AW-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (c2dk_pkg::OFIFO_AW+1)'(wr) - (c2dk_pkg::OFIFO_AW+1)'(rd);
    end
  end

  assign rdata    = mem[rptr];
  assign nonempty = (count != '0);

endmodule
`default_nettype wire

// File: src/conv2d_odd_kernel_valid_zero_border_core.sv
// Top level: 2D odd-kernel window sum with zero border over a raster stream.
// A result word passes pipeline stages 1 to 4 and is written into the output queue before it is offered.
// Throughput: one word per cycle; the 8-entry output queue, counted with the
// four pipeline stages, holds input off only while the output side stalls.
// Reset (rst, synchronous): registers to 8, 8, 3, 3, kernel to zero, counters
// and queue cleared; line store and window need no clearing pass.
`default_nettype none
module conv2d_odd_kernel_valid_zero_border_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [1:0]                            cfg_index,
  input  wire logic [c2dk_pkg::DIM_W-1:0]            cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            opcode,
  input  wire logic [2:0]                            coef_row,
  input  wire logic [2:0]                            coef_col,
  input  wire logic signed [c2dk_pkg::DATA_WIDTH-1:0] sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [c2dk_pkg::VAL_W-1:0]          out_value,
  output logic [c2dk_pkg::COL_W-1:0]                 out_row,
  output logic [c2dk_pkg::COL_W-1:0]                 out_col,
  output logic [1:0]                                 status,
  output logic                                       frame_end
);

  localparam int K  = c2dk_pkg::MAX_KERNEL;
  localparam int CW = c2dk_pkg::COL_W;
  localparam int DW = c2dk_pkg::DIM_W;

  logic [DW-1:0] image_rows, image_cols;
  logic [c2dk_pkg::KSZ_W-1:0] kernel_rows, kernel_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= DW'(8);
      image_cols  <= DW'(8);
      kernel_rows <= 3'd3;
      kernel_cols <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c2dk_pkg::REG_IMAGE_ROWS:  image_rows  <= cfg_data;
        c2dk_pkg::REG_IMAGE_COLS:  image_cols  <= cfg_data;
        c2dk_pkg::REG_KERNEL_ROWS: kernel_rows <= cfg_data[2:0];
        c2dk_pkg::REG_KERNEL_COLS: kernel_cols <= cfg_data[2:0];
      endcase
    end
  end

  logic [DW-1:0] rows_eff, cols_eff;
  logic [1:0] st;
  logic [1:0] hr, hc;

  assign rows_eff = (image_rows > DW'(c2dk_pkg::MAX_ROWS)) ? DW'(c2dk_pkg::MAX_ROWS) : image_rows;
  assign cols_eff = (image_cols > DW'(c2dk_pkg::MAX_COLS)) ? DW'(c2dk_pkg::MAX_COLS) : image_cols;
  assign hr = kernel_rows[2:1];
  assign hc = kernel_cols[2:1];

  always_comb begin
    priority if ((rows_eff < DW'(kernel_rows)) || (cols_eff < DW'(kernel_cols))) begin
      st = c2dk_pkg::ST_BIG;
    end else if (!kernel_rows[0] || !kernel_cols[0]) begin
      st = c2dk_pkg::ST_EVEN;
    end else begin
      st = c2dk_pkg::ST_OK;
    end
  end

  // input and output raster counters
  logic [CW-1:0] in_row, in_col, orow, ocol;
  logic [c2dk_pkg::SLOT_W-1:0] in_slot;

  logic accept;
  logic primed, out_nz, out_last_c, out_last, interior;
  logic col_last, row_last;

  assign accept     = in_valid && !in_stall;
  assign primed     = (in_row > CW'(hr)) || ((in_row == CW'(hr)) && (in_col >= CW'(hc)));
  assign out_nz     = (orow != '0) || (ocol != '0);
  assign out_last_c = ({1'b0, ocol} + DW'(1)) == cols_eff;
  assign out_last   = out_last_c && (({1'b0, orow} + DW'(1)) == rows_eff);
  assign interior   = (orow >= CW'(hr)) && (({1'b0, orow} + DW'(hr)) < rows_eff) &&
                      (ocol >= CW'(hc)) && (({1'b0, ocol} + DW'(hc)) < cols_eff);
  assign col_last   = ({1'b0, in_col} + DW'(1)) >= cols_eff;
  assign row_last   = ({1'b0, in_row} + DW'(1)) >= rows_eff;

  c2dk_pkg::meta_t a_meta;
  logic a_shift, a_kwe, a_adv;

  always_comb begin
    a_meta  = '0;
    a_shift = 1'b0;
    a_adv   = 1'b0;
    a_kwe   = (opcode == c2dk_pkg::OP_COEF) && (coef_row < 3'(K)) && (coef_col < 3'(K));
    if (st != c2dk_pkg::ST_OK) begin
      a_meta.res    = 1'b1;
      a_meta.status = st;
    end else if (opcode == c2dk_pkg::OP_PIXEL) begin
      a_shift = 1'b1;
      if (primed || out_nz) begin
        a_meta.res       = 1'b1;
        a_meta.use_sum   = primed && interior;
        a_meta.row       = orow;
        a_meta.col       = ocol;
        a_meta.frame_end = out_last;
        a_adv            = 1'b1;
      end
    end else if (opcode == c2dk_pkg::OP_DRAIN) begin
      // tail of the previous frame, all border
      if (!primed && out_nz) begin
        a_meta.res       = 1'b1;
        a_meta.row       = orow;
        a_meta.col       = ocol;
        a_meta.frame_end = out_last;
        a_adv            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      in_row  <= '0;
      in_col  <= '0;
      in_slot <= '0;
      orow    <= '0;
      ocol    <= '0;
    end else if (accept) begin
      if (a_shift) begin
        if (col_last) begin
          in_col <= '0;
          if (row_last) begin
            in_row  <= '0;
            in_slot <= '0;
          end else begin
            in_row  <= in_row + 1'b1;
            in_slot <= (in_slot == c2dk_pkg::SLOT_W'(c2dk_pkg::LINE_SLOTS - 1)) ?
                       '0 : in_slot + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (a_adv) begin
        if (out_last) begin
          orow <= '0;
          ocol <= '0;
        end else if (out_last_c) begin
          orow <= orow + 1'b1;
          ocol <= '0;
        end else begin
          ocol <= ocol + 1'b1;
        end
      end
    end
  end

  // stage 1: line store read, word registered
  c2dk_pkg::meta_t s1_meta, s2_meta, s3_meta, s4_meta;
  logic s1_shift, s1_kwe, s2_kwe;
  logic [2:0] s1_krow, s1_kcol, s2_krow, s2_kcol;
  c2dk_pkg::pix_t s1_data, s2_data;
  logic [CW-1:0] s1_r;
  logic [c2dk_pkg::SLOT_W-1:0] s1_slot;
  c2dk_pkg::line_col_t lb_rd;

  c2dk_line_buf u_line_buf (
    .clk   (clk),
    .en    (accept && a_shift),
    .addr  (in_col),
    .slot  (in_slot),
    .wdata (sample),
    .rdata (lb_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_meta  <= '0;
      s1_shift <= 1'b0;
      s1_kwe   <= 1'b0;
      s2_meta  <= '0;
      s2_kwe   <= 1'b0;
      s3_meta  <= '0;
      s4_meta  <= '0;
    end else begin
      s1_meta  <= accept ? a_meta : '0;
      s1_shift <= accept && a_shift;
      s1_kwe   <= accept && a_kwe;
      s2_meta  <= s1_meta;
      s2_kwe   <= s1_kwe;
      s3_meta  <= s2_meta;
      s4_meta  <= s3_meta;
    end
  end

  always_ff @(posedge clk) begin
    s1_krow <= coef_row;
    s1_kcol <= coef_col;
    s1_data <= sample;
    s1_r    <= in_row;
    s1_slot <= in_slot;
    s2_krow <= s1_krow;
    s2_kcol <= s1_kcol;
    s2_data <= s1_data;
  end

  // kernel written through the s1 and s2 registers to line up with the product stage
  c2dk_pkg::pix_t kernel [K][K];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          kernel[i][j] <= '0;
        end
      end
    end else if (s2_kwe) begin
      kernel[s2_krow][s2_kcol] <= s2_data;
    end
  end

  // stage 2: window shift; new right column from the line store and the new sample
  c2dk_pkg::pix_t win [K][K];
  c2dk_pkg::pix_t col_in [K];
  c2dk_pkg::pix_t cell_coef [K][K];
  logic signed [c2dk_pkg::PROD_W-1:0] prod [K][K];
  logic [2:0] km1;

  assign km1 = kernel_rows - 3'd1;

  always_comb begin
    logic [2:0] back;
    for (int i = 0; i < K; i++) begin
      back = km1 - 3'(i);
      if (3'(i) < km1) begin
        col_in[i] = (s1_r >= CW'(back)) ? lb_rd[c2dk_pkg::slot_back(s1_slot, back)] : '0;
      end else if (3'(i) == km1) begin
        col_in[i] = s1_data;
      end else begin
        col_in[i] = win[i][K-1];
      end
    end
  end

  // kernel sits right-aligned in the window
  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        if ((3'(i) < kernel_rows) && ((4'(j) + {1'b0, kernel_cols}) >= 4'(K))) begin
          cell_coef[i][j] = kernel[i][3'(4'(j) + {1'b0, kernel_cols} - 4'(K))];
        end else begin
          cell_coef[i][j] = '0;
        end
      end
    end
  end

  for (genvar gi = 0; gi < K; gi++) begin : g_row
    for (genvar gj = 0; gj < K; gj++) begin : g_col
      if (gj == K - 1) begin : g_edge
        c2dk_cell u_cell (
          .clk    (clk),
          .en     (s1_shift),
          .pix_in (col_in[gi]),
          .coef   (cell_coef[gi][gj]),
          .pix    (win[gi][gj]),
          .prod   (prod[gi][gj])
        );
      end else begin : g_mid
        c2dk_cell u_cell (
          .clk    (clk),
          .en     (s1_shift),
          .pix_in (win[gi][gj+1]),
          .coef   (cell_coef[gi][gj]),
          .pix    (win[gi][gj]),
          .prod   (prod[gi][gj])
        );
      end
    end
  end

  // stage 4: row sums; final sum on the way into the queue
  logic signed [c2dk_pkg::ROWSUM_W-1:0] rowsum [K];
  logic signed [c2dk_pkg::ROWSUM_W-1:0] rs_next [K];
  logic signed [c2dk_pkg::VAL_W-1:0] total;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      rs_next[i] = '0;
      for (int j = 0; j < K; j++) begin
        rs_next[i] = rs_next[i] + c2dk_pkg::ROWSUM_W'(prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < K; i++) begin
      rowsum[i] <= rs_next[i];
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < K; i++) begin
      total = total + c2dk_pkg::VAL_W'(rowsum[i]);
    end
  end

  c2dk_pkg::res_t q_wdata, q_rdata;
  logic [c2dk_pkg::OFIFO_AW:0] q_count;
  logic [2:0] inflight;

  always_comb begin
    q_wdata.value     = s4_meta.use_sum ? total : '0;
    q_wdata.row       = s4_meta.row;
    q_wdata.col       = s4_meta.col;
    q_wdata.status    = s4_meta.status;
    q_wdata.frame_end = s4_meta.frame_end;
  end

  c2dk_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (s4_meta.res),
    .wdata    (q_wdata),
    .rd       (out_valid && !out_stall),
    .rdata    (q_rdata),
    .nonempty (out_valid),
    .count    (q_count)
  );

  assign inflight = 3'(s1_meta.res) + 3'(s2_meta.res) + 3'(s3_meta.res) + 3'(s4_meta.res);
  assign in_stall = ({1'b0, q_count} + 5'(inflight)) >= 5'(c2dk_pkg::OFIFO_DEPTH);

  assign out_value = q_rdata.value;
  assign out_row   = q_rdata.row;
  assign out_col   = q_rdata.col;
  assign status    = q_rdata.status;
  assign frame_end = q_rdata.frame_end;

  // queue room covers every word still in the pipeline
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, q_count} + 5'(inflight)) <= 5'(c2dk_pkg::OFIFO_DEPTH))
    else $error("output queue overrun");

  a_status_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != c2dk_pkg::ST_OK)) |->
      ((out_value == '0) && !frame_end && (out_row == '0) && (out_col == '0)))
    else $error("status word carries pixel data");

  a_shift_ok: assert property (@(posedge clk) disable iff (rst)
    s1_shift |-> ($past(st) == c2dk_pkg::ST_OK))
    else $error("window shifted under bad configuration");

  a_sum_ok: assert property (@(posedge clk) disable iff (rst)
    s4_meta.use_sum |-> (s4_meta.res && (s4_meta.status == c2dk_pkg::ST_OK)))
    else $error("window sum on a word that is not a pixel result");

endmodule
`default_nettype wire
